FILE: hdl/pcpg_pkg.sv
`default_nettype none

package pcpg_pkg;

   // Default coordinate width of the point fields.
   localparam int COORD_WIDTH_DEF = 12;

   // Fixed field and state widths.
   localparam int RADIUS_WIDTH   = 9;
   localparam int OCTANT_WIDTH   = 10;
   localparam int DECISION_WIDTH = 14;
   localparam int BEAT_IDX_WIDTH = 3;

   // Request opcodes.
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // Index of the final beat of an eight-point circle run.
   localparam logic [BEAT_IDX_WIDTH-1:0] LAST_CIRCLE_BEAT = 3'd7;

   // Control of the run that the output stage is sending.
   typedef struct packed {
      logic                      circle;
      logic                      done;
      logic [BEAT_IDX_WIDTH-1:0] index;
   } beat_ctl_type;

endpackage

`default_nettype wire

FILE: hdl/pcpg_if.sv
`default_nettype none

interface pcpg_req_if #(
   parameter int COORD_WIDTH = pcpg_pkg::COORD_WIDTH_DEF
);
   import pcpg_pkg::*;

   logic                           valid;
   logic                           ready;
   logic                           op;
   logic signed [COORD_WIDTH-1:0]  center_x;
   logic signed [COORD_WIDTH-1:0]  center_y;
   logic        [RADIUS_WIDTH-1:0] radius;

   modport source (output valid, op, center_x, center_y, radius, input ready);
   modport sink   (input valid, op, center_x, center_y, radius, output ready);
endinterface

interface pcpg_rsp_if #(
   parameter int COORD_WIDTH = pcpg_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic                          last;
   logic                          done_res;

   modport source (output valid, point_x, point_y, last, done_res, input ready);
   modport sink   (input valid, point_x, point_y, last, done_res, output ready);
endinterface

`default_nettype wire

FILE: hdl/pcpg_point_sel.sv
`default_nettype none

// Forms one output point from a run descriptor and the beat index, with
// saturation to the coordinate range.
module pcpg_point_sel #(
   parameter int COORD_WIDTH = pcpg_pkg::COORD_WIDTH_DEF,
   parameter int LINE_WIDTH  = 14
) (
   input  wire logic signed [LINE_WIDTH-1:0]          base_x,
   input  wire logic signed [LINE_WIDTH-1:0]          base_y,
   input  wire logic        [pcpg_pkg::OCTANT_WIDTH-1:0] oct_x,
   input  wire logic        [pcpg_pkg::OCTANT_WIDTH-1:0] oct_y,
   input  wire pcpg_pkg::beat_ctl_type                ctl,
   output logic signed      [COORD_WIDTH-1:0]         point_x,
   output logic signed      [COORD_WIDTH-1:0]         point_y
);
   import pcpg_pkg::*;

   localparam int SW = LINE_WIDTH + 1;
   localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

   logic              swap;
   logic              neg_x;
   logic              neg_y;
   logic [OCTANT_WIDTH-1:0] off_x;
   logic [OCTANT_WIDTH-1:0] off_y;
   logic signed [SW-1:0] ext_x;
   logic signed [SW-1:0] ext_y;
   logic signed [SW-1:0] sum_x;
   logic signed [SW-1:0] sum_y;

   // The eight octant images: odd beats swap x and y, the upper half negates
   // the x offset, and beats two through five negate the y offset.
   always_comb begin
      swap  = ctl.circle & ctl.index[0];
      neg_x = ctl.circle & ctl.index[2];
      neg_y = ctl.circle & (ctl.index[2] ^ ctl.index[1]);
      off_x = ctl.circle ? (swap ? oct_y : oct_x) : '0;
      off_y = ctl.circle ? (swap ? oct_x : oct_y) : '0;
      ext_x = $signed({{(SW - OCTANT_WIDTH){1'b0}}, off_x});
      ext_y = $signed({{(SW - OCTANT_WIDTH){1'b0}}, off_y});
      sum_x = neg_x ? (SW'(base_x) - ext_x) : (SW'(base_x) + ext_x);
      sum_y = neg_y ? (SW'(base_y) - ext_y) : (SW'(base_y) + ext_y);

      if (sum_x > SAT_HI) begin
         point_x = SAT_HI[COORD_WIDTH-1:0];
      end else if (sum_x < SAT_LO) begin
         point_x = SAT_LO[COORD_WIDTH-1:0];
      end else begin
         point_x = sum_x[COORD_WIDTH-1:0];
      end

      if (sum_y > SAT_HI) begin
         point_y = SAT_HI[COORD_WIDTH-1:0];
      end else if (sum_y < SAT_LO) begin
         point_y = SAT_LO[COORD_WIDTH-1:0];
      end else begin
         point_y = sum_y[COORD_WIDTH-1:0];
      end
   end

endmodule

`default_nettype wire

FILE: hdl/pendulum_circle_point_generator.sv
// A step beat's run is registered into the send stage, or into the pending stage while that
// is busy, before its first point shows. Throughput: a circle step sends eight beats, one per
// cycle, and bar and stem steps and start beats run at one per cycle, while rsp is ready.
// The output run register and a one-entry pending stage set this rate.
// Reset (synchronous, active high) leaves the generator idle with no run pending.
`default_nettype none

module pendulum_circle_point_generator #(
   parameter int COORD_WIDTH = pcpg_pkg::COORD_WIDTH_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   pcpg_req_if.sink    req_bus,
   pcpg_rsp_if.source  rsp_bus
);
   import pcpg_pkg::*;

   // The bar and stem walk coordinates up to three radii past the centre,
   // so the walking position is at least two bits wider than a point.
   localparam int CW = COORD_WIDTH;
   localparam int LW = ((CW > 11) ? CW : 11) + 2;
   localparam int RW = RADIUS_WIDTH;
   localparam int OW = OCTANT_WIDTH;
   localparam int DW = DECISION_WIDTH;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_CIRCLE = 2'd1;
   localparam logic [1:0] PH_BAR    = 2'd2;
   localparam logic [1:0] PH_STEM   = 2'd3;

   localparam logic signed [DW-1:0] DEC_INIT     = DW'(3);
   localparam logic signed [DW-1:0] DEC_STEP_IN  = DW'(6);
   localparam logic signed [DW-1:0] DEC_STEP_OUT = DW'(10);

   // Generator state.
   logic [1:0]             phase_ff, phase_in;
   logic signed [CW-1:0]   cx_ff, cx_in;
   logic signed [CW-1:0]   cy_ff, cy_in;
   logic [RW-1:0]          r_ff, r_in;
   logic [OW-1:0]          ox_ff, ox_in;
   logic [OW-1:0]          oy_ff, oy_in;
   logic signed [DW-1:0]   dec_ff, dec_in;
   logic signed [LW-1:0]   lp_ff, lp_in;

   // Run descriptor built from the state when a step beat is taken.
   logic                   nd_valid;
   logic signed [LW-1:0]   nd_bx, nd_by;
   logic [OW-1:0]          nd_ox, nd_oy;
   logic                   nd_circle, nd_done;

   // Pending stage (A) and sending stage (B).
   logic                   a_valid_ff, a_valid_in;
   logic signed [LW-1:0]   a_bx_ff, a_bx_in, a_by_ff, a_by_in;
   logic [OW-1:0]          a_ox_ff, a_ox_in, a_oy_ff, a_oy_in;
   logic                   a_circle_ff, a_circle_in, a_done_ff, a_done_in;

   logic                   b_valid_ff, b_valid_in;
   logic signed [LW-1:0]   b_bx_ff, b_bx_in, b_by_ff, b_by_in;
   logic [OW-1:0]          b_ox_ff, b_ox_in, b_oy_ff, b_oy_in;
   logic                   b_circle_ff, b_circle_in, b_done_ff, b_done_in;
   logic [BEAT_IDX_WIDTH-1:0] idx_ff, idx_in;

   logic                   req_take;
   logic                   rsp_take;
   logic                   run_last;
   logic                   b_free;
   logic                   b_load_a;
   logic                   b_load_new;
   logic                   a_load;
   beat_ctl_type           beat_ctl;

   // Arithmetic helpers.
   logic signed [LW-1:0]   cx_l, cy_l, r_l, r3_l;
   logic signed [OW:0]     x_next, y_dec, y_next, xy_diff;
   logic signed [DW-1:0]   four_x, four_diff;

   assign req_take = req_bus.valid & req_bus.ready;
   assign rsp_take = rsp_bus.valid & rsp_bus.ready;
   assign run_last = ~b_circle_ff | (idx_ff == LAST_CIRCLE_BEAT);

   // The input side only waits when a run is already pending behind the one
   // being sent; a finished point waiting on rsp does not block a new beat.
   assign req_bus.ready = ~a_valid_ff;

   always_comb begin
      cx_l    = LW'(cx_ff);
      cy_l    = LW'(cy_ff);
      r_l     = $signed(LW'(r_ff));
      r3_l    = r_l + r_l + r_l;
      x_next  = $signed({1'b0, ox_ff}) + (OW + 1)'(1);
      y_dec   = $signed({1'b0, oy_ff}) - (OW + 1)'(1);
      y_next  = dec_ff[DW-1] ? $signed({1'b0, oy_ff}) : y_dec;
      xy_diff = $signed({1'b0, ox_ff}) - $signed({1'b0, oy_ff});
      four_x  = $signed({{(DW - OW - 2){1'b0}}, ox_ff, 2'b00});
      four_diff = $signed({{(DW - OW - 3){xy_diff[OW]}}, xy_diff, 2'b00});
   end

   // Generator state update and run descriptor for the beat being taken.
   always_comb begin
      phase_in  = phase_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      r_in      = r_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      dec_in    = dec_ff;
      lp_in     = lp_ff;
      nd_valid  = 1'b0;
      nd_bx     = cx_l;
      nd_by     = cy_l;
      nd_ox     = ox_ff;
      nd_oy     = oy_ff;
      nd_circle = 1'b0;
      nd_done   = 1'b0;

      if (req_take) begin
         if (req_bus.op == OP_START) begin
            // A start abandons any drawing in progress and sends nothing.
            cx_in    = req_bus.center_x;
            cy_in    = req_bus.center_y;
            r_in     = req_bus.radius;
            ox_in    = '0;
            oy_in    = OW'(req_bus.radius);
            dec_in   = DEC_INIT - $signed({{(DW - RW - 1){1'b0}}, req_bus.radius, 1'b0});
            lp_in    = '0;
            phase_in = PH_CIRCLE;
         end else begin
            case (phase_ff)
               PH_CIRCLE: begin
                  nd_valid  = 1'b1;
                  nd_circle = 1'b1;
                  // The decision update uses x before it advances.
                  if (dec_ff[DW-1]) begin
                     dec_in = dec_ff + four_x + DEC_STEP_IN;
                  end else begin
                     dec_in = dec_ff + four_diff + DEC_STEP_OUT;
                  end
                  ox_in = x_next[OW-1:0];
                  oy_in = y_next[OW-1:0];
                  if (x_next > y_next) begin
                     phase_in = PH_BAR;
                     lp_in    = cx_l - r_l;
                  end
               end
               PH_BAR: begin
                  nd_valid = 1'b1;
                  nd_bx    = lp_ff;
                  nd_by    = cy_l + r3_l;
                  if (lp_ff >= cx_l + r_l) begin
                     phase_in = PH_STEM;
                     lp_in    = cy_l + r_l;
                  end else begin
                     lp_in = lp_ff + LW'(1);
                  end
               end
               PH_STEM: begin
                  nd_valid = 1'b1;
                  nd_bx    = cx_l;
                  nd_by    = lp_ff;
                  if (lp_ff >= cy_l + r3_l) begin
                     nd_done  = 1'b1;
                     phase_in = PH_IDLE;
                  end else begin
                     lp_in = lp_ff + LW'(1);
                  end
               end
               default: begin
                  // Idle: a step before any start or after the end sends nothing.
               end
            endcase
         end
      end
   end

   // Run staging: B sends the current run; A holds one run behind it.
   always_comb begin
      b_free     = ~b_valid_ff | (rsp_take & run_last);
      b_load_a   = a_valid_ff & b_free;
      b_load_new = ~a_valid_ff & b_free & nd_valid;
      a_load     = nd_valid & ~b_load_new;

      a_valid_in  = a_valid_ff;
      a_bx_in     = a_bx_ff;
      a_by_in     = a_by_ff;
      a_ox_in     = a_ox_ff;
      a_oy_in     = a_oy_ff;
      a_circle_in = a_circle_ff;
      a_done_in   = a_done_ff;
      if (a_load) begin
         a_valid_in  = 1'b1;
         a_bx_in     = nd_bx;
         a_by_in     = nd_by;
         a_ox_in     = nd_ox;
         a_oy_in     = nd_oy;
         a_circle_in = nd_circle;
         a_done_in   = nd_done;
      end else if (b_load_a) begin
         a_valid_in = 1'b0;
      end

      b_valid_in  = b_valid_ff;
      b_bx_in     = b_bx_ff;
      b_by_in     = b_by_ff;
      b_ox_in     = b_ox_ff;
      b_oy_in     = b_oy_ff;
      b_circle_in = b_circle_ff;
      b_done_in   = b_done_ff;
      idx_in      = idx_ff;
      if (b_load_a) begin
         b_valid_in  = 1'b1;
         b_bx_in     = a_bx_ff;
         b_by_in     = a_by_ff;
         b_ox_in     = a_ox_ff;
         b_oy_in     = a_oy_ff;
         b_circle_in = a_circle_ff;
         b_done_in   = a_done_ff;
         idx_in      = '0;
      end else if (b_load_new) begin
         b_valid_in  = 1'b1;
         b_bx_in     = nd_bx;
         b_by_in     = nd_by;
         b_ox_in     = nd_ox;
         b_oy_in     = nd_oy;
         b_circle_in = nd_circle;
         b_done_in   = nd_done;
         idx_in      = '0;
      end else if (b_free) begin
         b_valid_in = 1'b0;
      end else if (rsp_take) begin
         idx_in = idx_ff + BEAT_IDX_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         phase_ff   <= phase_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         idx_ff     <= idx_in;
      end
   end

   // Datapath registers; they are only read after a start has loaded them.
   always_ff @(posedge clock) begin
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      r_ff        <= r_in;
      ox_ff       <= ox_in;
      oy_ff       <= oy_in;
      dec_ff      <= dec_in;
      lp_ff       <= lp_in;
      a_bx_ff     <= a_bx_in;
      a_by_ff     <= a_by_in;
      a_ox_ff     <= a_ox_in;
      a_oy_ff     <= a_oy_in;
      a_circle_ff <= a_circle_in;
      a_done_ff   <= a_done_in;
      b_bx_ff     <= b_bx_in;
      b_by_ff     <= b_by_in;
      b_ox_ff     <= b_ox_in;
      b_oy_ff     <= b_oy_in;
      b_circle_ff <= b_circle_in;
      b_done_ff   <= b_done_in;
   end

   assign beat_ctl.circle = b_circle_ff;
   assign beat_ctl.done   = b_done_ff;
   assign beat_ctl.index  = idx_ff;

   pcpg_point_sel #(
      .COORD_WIDTH (CW),
      .LINE_WIDTH  (LW)
   ) u_point_sel (
      .base_x  (b_bx_ff),
      .base_y  (b_by_ff),
      .oct_x   (b_ox_ff),
      .oct_y   (b_oy_ff),
      .ctl     (beat_ctl),
      .point_x (rsp_bus.point_x),
      .point_y (rsp_bus.point_y)
   );

   assign rsp_bus.valid    = b_valid_ff;
   assign rsp_bus.last     = run_last;
   assign rsp_bus.done_res = b_done_ff & run_last;

   // A pending run never waits behind an empty send stage.
   assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !b_valid_ff) |=> b_valid_ff)
      else $error("pending run stalled with an empty send stage");

   // A beat taken inside a circle run advances to the next octant image.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !run_last) |=> (b_valid_ff && idx_ff == $past(idx_ff) + BEAT_IDX_WIDTH'(1)))
      else $error("circle run did not advance by one beat");

   // While the circle runs, the octant point stays on or above the diagonal.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CIRCLE) |-> (ox_ff <= oy_ff))
      else $error("circle phase past the octant boundary");

   // The final stem point returns the generator to idle.
   assert property (@(posedge clock) disable iff (reset)
      (nd_valid && nd_done) |=> (phase_ff == PH_IDLE))
      else $error("generator not idle after the final point");

endmodule

`default_nettype wire
